@@ hw/rtl/vps_pkg.sv @@
// ----------------------------------------------------------------------------
// vps_pkg
// Shared widths, codes and the control store of the vertex path stepper.
// ----------------------------------------------------------------------------
package vps_pkg;

   localparam int FIELD_W    = 16;
   localparam int KIND_W     = 2;
   localparam int SLOT_W     = 4;
   localparam int WAIT_W     = 26;
   localparam int VNOW_W     = 4;
   localparam int DIV_W      = 10;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam int EXT_W      = 34;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int CENTER_POS       = 1500;
   localparam int US_PER_UNIT      = 1000;
   localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_DIVISOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT = 1'd1;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_WRITE     = 4'd1;
   localparam logic [OP_W-1:0] OP_ZERO_WAIT = 4'd2;
   localparam logic [OP_W-1:0] OP_CENTER    = 4'd3;
   localparam logic [OP_W-1:0] OP_DIFF      = 4'd4;
   localparam logic [OP_W-1:0] OP_ADVANCE   = 4'd5;
   localparam logic [OP_W-1:0] OP_LOAD      = 4'd6;
   localparam logic [OP_W-1:0] OP_DIV_INIT  = 4'd7;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd8;
   localparam logic [OP_W-1:0] OP_STRIDE    = 4'd9;
   localparam logic [OP_W-1:0] OP_CLIP      = 4'd10;
   localparam logic [OP_W-1:0] OP_MAX       = 4'd11;
   localparam logic [OP_W-1:0] OP_WAIT      = 4'd12;
   localparam logic [OP_W-1:0] OP_MOVE      = 4'd13;
   localparam logic [OP_W-1:0] OP_EMIT      = 4'd14;

   // sequencing conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] C_DISPATCH = 3'd2;
   localparam logic [COND_W-1:0] C_NOT_AT   = 3'd3;
   localparam logic [COND_W-1:0] C_LOOP     = 3'd4;
   localparam logic [COND_W-1:0] C_NOT_TICK = 3'd5;
   localparam logic [COND_W-1:0] C_EMIT     = 3'd6;

   // program addresses
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] P_IDLE    = 5'd0;
   localparam logic [PC_W-1:0] P_WRITE   = 5'd1;
   localparam logic [PC_W-1:0] P_NOKIND  = 5'd2;
   localparam logic [PC_W-1:0] P_RESTART = 5'd3;
   localparam logic [PC_W-1:0] P_TICK    = 5'd4;
   localparam logic [PC_W-1:0] P_ADVANCE = 5'd5;
   localparam logic [PC_W-1:0] P_FETCH   = 5'd6;
   localparam logic [PC_W-1:0] P_LOAD    = 5'd7;
   localparam logic [PC_W-1:0] P_DIFF    = 5'd8;
   localparam logic [PC_W-1:0] P_DIVINIT = 5'd9;
   localparam logic [PC_W-1:0] P_DIVSTEP = 5'd10;
   localparam logic [PC_W-1:0] P_STRIDE  = 5'd11;
   localparam logic [PC_W-1:0] P_CLIP    = 5'd12;
   localparam logic [PC_W-1:0] P_MAX     = 5'd13;
   localparam logic [PC_W-1:0] P_WAIT    = 5'd14;
   localparam logic [PC_W-1:0] P_MOVE    = 5'd15;
   localparam logic [PC_W-1:0] P_EMIT    = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } uop_type;

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         P_IDLE:    u = '{op: OP_NOP,       cond: C_DISPATCH, target: P_IDLE};
         P_WRITE:   u = '{op: OP_WRITE,     cond: C_ALWAYS,   target: P_EMIT};
         P_NOKIND:  u = '{op: OP_ZERO_WAIT, cond: C_ALWAYS,   target: P_EMIT};
         P_RESTART: u = '{op: OP_CENTER,    cond: C_ALWAYS,   target: P_FETCH};
         P_TICK:    u = '{op: OP_DIFF,      cond: C_NOT_AT,   target: P_CLIP};
         P_ADVANCE: u = '{op: OP_ADVANCE,   cond: C_NEXT,     target: P_IDLE};
         P_FETCH:   u = '{op: OP_NOP,       cond: C_NEXT,     target: P_IDLE};
         P_LOAD:    u = '{op: OP_LOAD,      cond: C_NEXT,     target: P_IDLE};
         P_DIFF:    u = '{op: OP_DIFF,      cond: C_NEXT,     target: P_IDLE};
         P_DIVINIT: u = '{op: OP_DIV_INIT,  cond: C_NEXT,     target: P_IDLE};
         P_DIVSTEP: u = '{op: OP_DIV_STEP,  cond: C_LOOP,     target: P_DIVSTEP};
         P_STRIDE:  u = '{op: OP_STRIDE,    cond: C_NEXT,     target: P_IDLE};
         P_CLIP:    u = '{op: OP_CLIP,      cond: C_NEXT,     target: P_IDLE};
         P_MAX:     u = '{op: OP_MAX,       cond: C_NEXT,     target: P_IDLE};
         P_WAIT:    u = '{op: OP_WAIT,      cond: C_NOT_TICK, target: P_EMIT};
         P_MOVE:    u = '{op: OP_MOVE,      cond: C_NEXT,     target: P_IDLE};
         P_EMIT:    u = '{op: OP_EMIT,      cond: C_EMIT,     target: P_IDLE};
         default:   u = '{op: OP_NOP,       cond: C_ALWAYS,   target: P_IDLE};
      endcase
      return u;
   endfunction

   function automatic logic [PC_W-1:0] entry_of(input logic [KIND_W-1:0] kind);
      logic [PC_W-1:0] pc;
      case (kind)
         KIND_WRITE:   pc = P_WRITE;
         KIND_RESTART: pc = P_RESTART;
         KIND_TICK:    pc = P_TICK;
         default:      pc = P_NOKIND;
      endcase
      return pc;
   endfunction

endpackage

@@ hw/rtl/vps_req_if.sv @@
// ----------------------------------------------------------------------------
// vps_req_if
// Request channel: one vertex write, restart or tick word.
// ----------------------------------------------------------------------------
interface vps_req_if;
   logic                               valid;
   logic                               ready;
   logic [vps_pkg::KIND_W-1:0]         kind;
   logic [vps_pkg::SLOT_W-1:0]         vertex_slot;
   logic signed [vps_pkg::FIELD_W-1:0] vertex_x;
   logic signed [vps_pkg::FIELD_W-1:0] vertex_y;
   logic                               vertex_draw;

   modport source (output valid, kind, vertex_slot, vertex_x, vertex_y, vertex_draw,
                   input ready);
   modport sink (input valid, kind, vertex_slot, vertex_x, vertex_y, vertex_draw,
                 output ready);
endinterface

@@ hw/rtl/vps_rsp_if.sv @@
// ----------------------------------------------------------------------------
// vps_rsp_if
// Response channel: position, laser, wait time and current vertex.
// ----------------------------------------------------------------------------
interface vps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [vps_pkg::FIELD_W-1:0] servo_x;
   logic signed [vps_pkg::FIELD_W-1:0] servo_y;
   logic                               laser_on;
   logic [vps_pkg::WAIT_W-1:0]         wait_us;
   logic [vps_pkg::VNOW_W-1:0]         vertex_now;

   modport source (output valid, servo_x, servo_y, laser_on, wait_us, vertex_now,
                   input ready);
   modport sink (input valid, servo_x, servo_y, laser_on, wait_us, vertex_now,
                 output ready);
endinterface

@@ hw/rtl/vps_csr_if.sv @@
// ----------------------------------------------------------------------------
// vps_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [vps_pkg::CSR_IDX_W-1:0]     index;
   logic [vps_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/vps_ram.sv @@
// ----------------------------------------------------------------------------
// vps_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module vps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/vertex_path_stepper.sv @@
// ----------------------------------------------------------------------------
// vertex_path_stepper
// Traces a closed polygon of stored vertices with two servo axes, one step
// per tick, under control of a small microcoded sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake    payload
// req_bus   in   valid/ready  kind, vertex_slot, vertex_x, vertex_y, vertex_draw
// rsp_bus   out  valid/ready  servo_x, servo_y, laser_on, wait_us, vertex_now
// csr_bus   in   valid/ready  index (0 step_divisor, 1 vertex_count), data
//
// One word at a time. Ticks that move to the next vertex and restarts run
// the bit-serial divider loop (one quotient bit per cycle, both axes in
// parallel); writes and ticks between vertices skip it.
// Synchronous reset restores center position, vertex 0, divisor 1, count 1;
// the vertex table is not cleared. A held response stalls only the final step.
// ----------------------------------------------------------------------------
module vertex_path_stepper #(
   parameter int MAX_VERTICES = vps_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = vps_pkg::COORD_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   vps_req_if.sink   req_bus,
   vps_rsp_if.source rsp_bus,
   vps_csr_if.sink   csr_bus
);

   localparam int CW  = COORD_WIDTH;
   localparam int IW  = $clog2(MAX_VERTICES);
   localparam int IXW = IW + 6;
   localparam int XW  = vps_pkg::EXT_W;
   localparam int DW  = vps_pkg::DIV_W;
   localparam int FW  = vps_pkg::FIELD_W;
   localparam int WW  = vps_pkg::WAIT_W;
   localparam int LW  = $clog2(CW + 1);
   localparam int PW  = (CW + DW > WW) ? CW + DW : WW;
   localparam int RW  = 2 * CW + 1;
   localparam logic signed [XW-1:0] CHI = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [XW-1:0] CLO = -CHI - 1;
   localparam logic [CW-1:0] HI_MAG = {1'b0, {(CW - 1){1'b1}}};
   localparam logic [CW-1:0] LO_MAG = {1'b1, {(CW - 1){1'b0}}};
   localparam logic [CW-1:0] CENTER = CW'(vps_pkg::CENTER_POS);

   function automatic logic signed [CW-1:0] sat_in(input logic signed [FW-1:0] v);
      logic signed [XW-1:0] w;
      w = XW'(v);
      if (w > CHI) sat_in = CHI[CW-1:0];
      else if (w < CLO) sat_in = CLO[CW-1:0];
      else sat_in = w[CW-1:0];
   endfunction

   function automatic logic [FW-1:0] out_field(input logic signed [CW-1:0] v);
      logic signed [XW-1:0] w;
      w = XW'(v);
      out_field = w[FW-1:0];
   endfunction

   // sequencer
   logic [vps_pkg::PC_W-1:0] pc_ff, pc_in;
   vps_pkg::uop_type         uop;

   // architectural state, lane 0 is x, lane 1 is y
   logic signed [CW-1:0] pos_ff [2];
   logic signed [CW-1:0] pos_in [2];
   logic signed [CW-1:0] tgt_ff [2];
   logic signed [CW-1:0] tgt_in [2];
   logic signed [CW-1:0] str_ff [2];
   logic signed [CW-1:0] str_in [2];
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 laser_ff, laser_in;
   logic [DW-1:0]        sdiv_ff, sdiv_in;
   logic [vps_pkg::CNT_W-1:0] vcnt_ff, vcnt_in;

   // working registers
   logic signed [CW:0] diff_ff [2];
   logic signed [CW:0] diff_in [2];
   logic [CW-1:0]      adiff_ff [2];
   logic [CW-1:0]      adiff_in [2];
   logic [CW-1:0]      dvd_ff [2];
   logic [CW-1:0]      dvd_in [2];
   logic [DW-1:0]      rem_ff [2];
   logic [DW-1:0]      rem_in [2];
   logic signed [CW:0] mov_ff [2];
   logic signed [CW:0] mov_in [2];
   logic [CW-1:0]      amov_ff [2];
   logic [CW-1:0]      amov_in [2];
   logic [CW-1:0]      mag_ff, mag_in;
   logic [LW-1:0]      loop_ff, loop_in;
   logic [WW-1:0]      wait_ff, wait_in;

   // latched request word
   logic [vps_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [vps_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic signed [CW-1:0]       vx_ff, vx_in;
   logic signed [CW-1:0]       vy_ff, vy_in;
   logic                       vd_ff, vd_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                rsp_x_ff, rsp_x_in;
   logic [FW-1:0]                rsp_y_ff, rsp_y_in;
   logic                         rsp_laser_ff, rsp_laser_in;
   logic [WW-1:0]                rsp_wait_ff, rsp_wait_in;
   logic [vps_pkg::VNOW_W-1:0]   rsp_vnow_ff, rsp_vnow_in;

   logic          req_fire, csr_fire, out_free, at_target, slot_ok, ram_we;
   logic [IXW-1:0] nxt_wide, cnt_lim;
   logic [IW-1:0]  idx_next, ram_waddr;
   logic [IW+3:0]  slot_wide, idx_wide;
   logic [RW-1:0]  ram_wdata, ram_rdata;
   logic [DW-1:0]  div_eff;

   vps_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_VERTICES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign uop       = vps_pkg::ucode(pc_ff);
   assign req_bus.ready = (pc_ff == vps_pkg::P_IDLE);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire  = csr_bus.valid && csr_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign at_target = (pos_ff[0] == tgt_ff[0]) && (pos_ff[1] == tgt_ff[1]);
   assign div_eff   = (sdiv_ff == '0) ? DW'(1) : sdiv_ff;

   assign nxt_wide  = IXW'(idx_ff) + IXW'(1);
   assign cnt_lim   = (IXW'(vcnt_ff) > IXW'(MAX_VERTICES)) ? IXW'(MAX_VERTICES)
                                                            : IXW'(vcnt_ff);
   assign idx_next  = (nxt_wide >= cnt_lim) ? '0 : nxt_wide[IW-1:0];
   assign slot_ok   = IXW'(slot_ff) < IXW'(MAX_VERTICES);
   assign slot_wide = (IW + 4)'(slot_ff);
   assign idx_wide  = (IW + 4)'(idx_ff);
   assign ram_waddr = slot_wide[IW-1:0];
   assign ram_wdata = {vd_ff, vy_ff, vx_ff};

   // next program address
   always_comb begin
      case (uop.cond)
         vps_pkg::C_NEXT:     pc_in = pc_ff + 1'b1;
         vps_pkg::C_ALWAYS:   pc_in = uop.target;
         vps_pkg::C_DISPATCH: pc_in = req_fire ? vps_pkg::entry_of(req_bus.kind) : pc_ff;
         vps_pkg::C_NOT_AT:   pc_in = at_target ? pc_ff + 1'b1 : uop.target;
         vps_pkg::C_LOOP:     pc_in = (loop_ff != LW'(1)) ? uop.target : pc_ff + 1'b1;
         vps_pkg::C_NOT_TICK: pc_in = (kind_ff != vps_pkg::KIND_TICK) ? uop.target
                                                                     : pc_ff + 1'b1;
         vps_pkg::C_EMIT:     pc_in = out_free ? uop.target : pc_ff;
         default:             pc_in = vps_pkg::P_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      logic [DW:0]          rem_sh;
      logic [DW+1:0]        trial;
      logic                 ge;
      logic [CW-1:0]        qf;
      logic [CW-1:0]        astr;
      logic signed [CW:0]   te;
      logic signed [CW:0]   pe;
      logic signed [XW-1:0] sumw;
      logic [PW-1:0]        prod;

      rem_sh = '0;
      trial  = '0;
      ge     = 1'b0;
      qf     = '0;
      astr   = '0;
      te     = '0;
      pe     = '0;
      sumw   = '0;
      prod   = '0;

      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      str_in   = str_ff;
      idx_in   = idx_ff;
      laser_in = laser_ff;
      sdiv_in  = sdiv_ff;
      vcnt_in  = vcnt_ff;
      diff_in  = diff_ff;
      adiff_in = adiff_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      mov_in   = mov_ff;
      amov_in  = amov_ff;
      mag_in   = mag_ff;
      loop_in  = loop_ff;
      wait_in  = wait_ff;
      kind_in  = kind_ff;
      slot_in  = slot_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      vd_in    = vd_ff;
      ram_we   = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_laser_in = rsp_laser_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_vnow_in  = rsp_vnow_ff;

      if (csr_fire) begin
         case (csr_bus.index)
            vps_pkg::REG_STEP_DIVISOR: sdiv_in = csr_bus.data[DW-1:0];
            vps_pkg::REG_VERTEX_COUNT: vcnt_in = csr_bus.data[vps_pkg::CNT_W-1:0];
            default: ;
         endcase
      end

      if (req_fire) begin
         kind_in = req_bus.kind;
         slot_in = req_bus.vertex_slot;
         vx_in   = sat_in(req_bus.vertex_x);
         vy_in   = sat_in(req_bus.vertex_y);
         vd_in   = req_bus.vertex_draw;
      end

      case (uop.op)
         vps_pkg::OP_WRITE: begin
            ram_we  = slot_ok;
            wait_in = '0;
         end
         vps_pkg::OP_ZERO_WAIT: begin
            wait_in = '0;
         end
         vps_pkg::OP_CENTER: begin
            pos_in = '{CENTER, CENTER};
            tgt_in = '{CENTER, CENTER};
            idx_in = '0;
         end
         vps_pkg::OP_DIFF: begin
            for (int i = 0; i < 2; i++) begin
               te          = (CW + 1)'(tgt_ff[i]);
               pe          = (CW + 1)'(pos_ff[i]);
               diff_in[i]  = te - pe;
               adiff_in[i] = (te >= pe) ? CW'(te - pe) : CW'(pe - te);
            end
         end
         vps_pkg::OP_ADVANCE: begin
            idx_in = idx_next;
         end
         vps_pkg::OP_LOAD: begin
            tgt_in[0] = ram_rdata[CW-1:0];
            tgt_in[1] = ram_rdata[2*CW-1:CW];
            laser_in  = ram_rdata[2*CW];
         end
         vps_pkg::OP_DIV_INIT: begin
            dvd_in  = adiff_ff;
            rem_in  = '{'0, '0};
            loop_in = LW'(CW);
         end
         vps_pkg::OP_DIV_STEP: begin
            loop_in = loop_ff - 1'b1;
            for (int i = 0; i < 2; i++) begin
               rem_sh    = {rem_ff[i], dvd_ff[i][CW-1]};
               trial     = {1'b0, rem_sh} - {2'b00, div_eff};
               ge        = !trial[DW+1];
               rem_in[i] = ge ? trial[DW-1:0] : rem_sh[DW-1:0];
               dvd_in[i] = {dvd_ff[i][CW-2:0], ge};
            end
         end
         vps_pkg::OP_STRIDE: begin
            for (int i = 0; i < 2; i++) begin
               qf = ((adiff_ff[i] != '0) && (dvd_ff[i] == '0)) ? CW'(1) : dvd_ff[i];
               if (!diff_ff[i][CW]) begin
                  str_in[i] = (qf > HI_MAG) ? HI_MAG : qf;
               end else begin
                  str_in[i] = (qf > LO_MAG) ? LO_MAG : (~qf) + CW'(1);
               end
            end
         end
         vps_pkg::OP_CLIP: begin
            for (int i = 0; i < 2; i++) begin
               astr = str_ff[i][CW-1] ? (~str_ff[i]) + CW'(1) : str_ff[i];
               if (adiff_ff[i] < astr) begin
                  mov_in[i]  = diff_ff[i];
                  amov_in[i] = adiff_ff[i];
               end else begin
                  mov_in[i]  = (CW + 1)'(str_ff[i]);
                  amov_in[i] = astr;
               end
            end
         end
         vps_pkg::OP_MAX: begin
            mag_in = (amov_ff[0] >= amov_ff[1]) ? amov_ff[0] : amov_ff[1];
         end
         vps_pkg::OP_WAIT: begin
            prod    = PW'(mag_ff) * PW'(vps_pkg::US_PER_UNIT);
            wait_in = (prod > PW'(vps_pkg::WAIT_MAX)) ? vps_pkg::WAIT_MAX : prod[WW-1:0];
         end
         vps_pkg::OP_MOVE: begin
            for (int i = 0; i < 2; i++) begin
               sumw = XW'(pos_ff[i]) + XW'(mov_ff[i]);
               if (sumw > CHI) pos_in[i] = CHI[CW-1:0];
               else if (sumw < CLO) pos_in[i] = CLO[CW-1:0];
               else pos_in[i] = sumw[CW-1:0];
            end
         end
         vps_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = out_field(pos_ff[0]);
               rsp_y_in     = out_field(pos_ff[1]);
               rsp_laser_in = laser_ff;
               rsp_wait_in  = wait_ff;
               rsp_vnow_in  = idx_wide[vps_pkg::VNOW_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= vps_pkg::P_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '{CENTER, CENTER};
         tgt_ff       <= '{CENTER, CENTER};
         str_ff       <= '{'0, '0};
         idx_ff       <= '0;
         laser_ff     <= 1'b0;
         sdiv_ff      <= DW'(1);
         vcnt_ff      <= vps_pkg::CNT_W'(1);
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
         str_ff       <= str_in;
         idx_ff       <= idx_in;
         laser_ff     <= laser_in;
         sdiv_ff      <= sdiv_in;
         vcnt_ff      <= vcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff      <= diff_in;
      adiff_ff     <= adiff_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      mov_ff       <= mov_in;
      amov_ff      <= amov_in;
      mag_ff       <= mag_in;
      loop_ff      <= loop_in;
      wait_ff      <= wait_in;
      kind_ff      <= kind_in;
      slot_ff      <= slot_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      vd_ff        <= vd_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_laser_ff <= rsp_laser_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_vnow_ff  <= rsp_vnow_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.servo_x    = rsp_x_ff;
   assign rsp_bus.servo_y    = rsp_y_ff;
   assign rsp_bus.laser_on   = rsp_laser_ff;
   assign rsp_bus.wait_us    = rsp_wait_ff;
   assign rsp_bus.vertex_now = rsp_vnow_ff;

   a_word_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pc_ff != vps_pkg::P_IDLE)
      else $error("sequencer stayed idle after taking a word");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == vps_pkg::P_EMIT)
      else $error("response raised outside the emit step");

   a_div_loop_live: assert property (@(posedge clock) disable iff (reset)
      pc_ff == vps_pkg::P_DIVSTEP |-> loop_ff != '0)
      else $error("divider loop count ran out");

   a_move_clipped: assert property (@(posedge clock) disable iff (reset)
      pc_ff == vps_pkg::P_MAX |-> (amov_ff[0] <= adiff_ff[0]) && (amov_ff[1] <= adiff_ff[1]))
      else $error("move exceeds remaining distance");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      IXW'(idx_ff) < IXW'(MAX_VERTICES))
      else $error("vertex index beyond table");

endmodule
